// ===== sv/vrlp_pkg.sv =====
package vrlp_pkg;

  localparam logic [7:0] TAG_RECORD = 8'h0A;
  localparam logic [7:0] TAG_ID     = 8'h08;
  localparam logic [7:0] TAG_NAME   = 8'h12;

  localparam logic [2:0] KIND_NAME_START = 3'd0;
  localparam logic [2:0] KIND_NAME_BYTE  = 3'd1;
  localparam logic [2:0] KIND_RECORD_END = 3'd2;
  localparam logic [2:0] KIND_STOPPED    = 3'd3;
  localparam logic [2:0] KIND_STREAM_END = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] record_id;
    logic [7:0]  name_char;
    logic        run_last;
  } out_item_t;

  // results caused by one byte, in emit order: lead, record end, stream end
  typedef struct packed {
    logic        lead_vld;
    logic [2:0]  lead_kind;
    logic        rec_end;
    logic        strm_end;
    logic [31:0] id;
    logic [7:0]  ch;
  } bundle_t;

endpackage

// ===== sv/vrlp_front.sv =====
module vrlp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  vrlp_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_push,
  output vrlp_pkg::bundle_t q_data
);
  import vrlp_pkg::*;

  typedef enum logic [6:0] {
    PH_TOP  = 7'b0000001,
    PH_RLEN = 7'b0000010,
    PH_TAG  = 7'b0000100,
    PH_ID   = 7'b0001000,
    PH_SLEN = 7'b0010000,
    PH_STR  = 7'b0100000,
    PH_STOP = 7'b1000000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [2:0]  group_r, group_nxt;
  logic [31:0] rec_left_r, rec_left_nxt;
  logic [31:0] str_left_r, str_left_nxt;
  logic [31:0] cur_id_r, cur_id_nxt;

  logic [7:0]  b;
  logic        accept;
  logic [31:0] shifted;
  logic [31:0] vt_val;
  logic        vt_done;
  logic [2:0]  vt_group;
  logic [31:0] rec_used;
  logic [31:0] str_dec;
  bundle_t     bnd;

  assign b       = in_item.data_byte;
  assign accept  = in_push && !q_full;
  assign vt_done = !b[7];

  always_comb begin
    case (group_r)
      3'd0:    shifted = {25'd0, b[6:0]};
      3'd1:    shifted = {18'd0, b[6:0], 7'd0};
      3'd2:    shifted = {11'd0, b[6:0], 14'd0};
      3'd3:    shifted = {4'd0, b[6:0], 21'd0};
      3'd4:    shifted = {b[3:0], 28'd0};
      default: shifted = 32'd0;
    endcase
  end

  assign vt_val   = accum_r | shifted;
  assign vt_group = (group_r < 3'd5) ? group_r + 3'd1 : group_r;
  assign rec_used = (rec_left_r != 32'd0) ? rec_left_r - 32'd1 : 32'd0;
  assign str_dec  = (str_left_r != 32'd0) ? str_left_r - 32'd1 : 32'd0;

  always_comb begin
    phase_nxt    = phase_r;
    accum_nxt    = accum_r;
    group_nxt    = group_r;
    rec_left_nxt = rec_left_r;
    str_left_nxt = str_left_r;
    cur_id_nxt   = cur_id_r;
    bnd.lead_vld  = 1'b0;
    bnd.lead_kind = KIND_NAME_START;
    bnd.rec_end   = 1'b0;
    bnd.strm_end  = 1'b0;
    bnd.ch        = b;
    case (phase_r)
      PH_TOP: begin
        if (b == TAG_RECORD) begin
          cur_id_nxt = 32'd0;
          accum_nxt  = 32'd0;
          group_nxt  = 3'd0;
          phase_nxt  = PH_RLEN;
        end else begin
          bnd.lead_vld  = 1'b1;
          bnd.lead_kind = KIND_STOPPED;
          phase_nxt     = PH_STOP;
        end
      end
      PH_RLEN: begin
        accum_nxt = vt_val;
        group_nxt = vt_group;
        if (vt_done) begin
          rec_left_nxt = vt_val;
          if (vt_val == 32'd0) begin
            bnd.rec_end = 1'b1;
            phase_nxt   = PH_TOP;
          end else begin
            phase_nxt = PH_TAG;
          end
        end
      end
      PH_TAG: begin
        rec_left_nxt = rec_used;
        if (b == TAG_ID) begin
          accum_nxt = 32'd0;
          group_nxt = 3'd0;
          phase_nxt = PH_ID;
        end else if (b == TAG_NAME) begin
          accum_nxt = 32'd0;
          group_nxt = 3'd0;
          phase_nxt = PH_SLEN;
        end else if (rec_used == 32'd0) begin
          bnd.rec_end = 1'b1;
          phase_nxt   = PH_TOP;
        end
      end
      PH_ID: begin
        rec_left_nxt = rec_used;
        accum_nxt    = vt_val;
        group_nxt    = vt_group;
        if (vt_done) begin
          cur_id_nxt = vt_val;
          if (rec_used == 32'd0) begin
            bnd.rec_end = 1'b1;
            phase_nxt   = PH_TOP;
          end else begin
            phase_nxt = PH_TAG;
          end
        end
      end
      PH_SLEN: begin
        rec_left_nxt = rec_used;
        accum_nxt    = vt_val;
        group_nxt    = vt_group;
        if (vt_done) begin
          str_left_nxt  = vt_val;
          bnd.lead_vld  = 1'b1;
          bnd.lead_kind = KIND_NAME_START;
          if (vt_val != 32'd0) begin
            phase_nxt = PH_STR;
          end else if (rec_used == 32'd0) begin
            bnd.rec_end = 1'b1;
            phase_nxt   = PH_TOP;
          end else begin
            phase_nxt = PH_TAG;
          end
        end
      end
      PH_STR: begin
        rec_left_nxt  = rec_used;
        str_left_nxt  = str_dec;
        bnd.lead_vld  = 1'b1;
        bnd.lead_kind = KIND_NAME_BYTE;
        if (str_dec == 32'd0) begin
          if (rec_used == 32'd0) begin
            bnd.rec_end = 1'b1;
            phase_nxt   = PH_TOP;
          end else begin
            phase_nxt = PH_TAG;
          end
        end
      end
      default: begin
      end
    endcase
    bnd.id = cur_id_nxt;
    if (in_item.last_byte) begin
      // flush an open record, then close the stream
      if (phase_nxt != PH_TOP && phase_nxt != PH_STOP) begin
        bnd.rec_end = 1'b1;
      end
      bnd.strm_end = 1'b1;
      phase_nxt    = PH_TOP;
      accum_nxt    = 32'd0;
      group_nxt    = 3'd0;
      rec_left_nxt = 32'd0;
      str_left_nxt = 32'd0;
      cur_id_nxt   = 32'd0;
    end
  end

  assign q_push = accept && (bnd.lead_vld || bnd.rec_end || bnd.strm_end);
  assign q_data = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TOP;
      accum_r    <= 32'd0;
      group_r    <= 3'd0;
      rec_left_r <= 32'd0;
      str_left_r <= 32'd0;
      cur_id_r   <= 32'd0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      accum_r    <= accum_nxt;
      group_r    <= group_nxt;
      rec_left_r <= rec_left_nxt;
      str_left_r <= str_left_nxt;
      cur_id_r   <= cur_id_nxt;
    end
  end

endmodule

// ===== sv/vrlp_queue.sv =====
module vrlp_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  vrlp_pkg::bundle_t push_data,
  output logic              full,
  input  logic              pop,
  output vrlp_pkg::bundle_t pop_data,
  output logic              empty
);
  import vrlp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t         mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/vrlp_back.sv =====
module vrlp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  vrlp_pkg::bundle_t  q_data,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output vrlp_pkg::out_item_t out_item
);
  import vrlp_pkg::*;

  bundle_t   cur_r, cur_nxt;
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_r, out_nxt;
  logic [1:0] pend;
  logic      adv;
  logic      load;

  assign pend  = 2'(cur_r.lead_vld) + 2'(cur_r.rec_end) + 2'(cur_r.strm_end);
  assign adv   = !out_vld_r || out_pop;
  assign load  = (pend == 2'd0) || (adv && pend == 2'd1);
  assign q_pop = load && !q_empty;

  always_comb begin
    cur_nxt     = cur_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_pop;
    if (adv && pend != 2'd0) begin
      out_vld_nxt       = 1'b1;
      out_nxt.record_id = 32'd0;
      out_nxt.name_char = 8'd0;
      out_nxt.run_last  = (pend == 2'd1);
      if (cur_r.lead_vld) begin
        out_nxt.kind = cur_r.lead_kind;
        if (cur_r.lead_kind == KIND_NAME_BYTE) begin
          out_nxt.name_char = cur_r.ch;
        end
        cur_nxt.lead_vld = 1'b0;
      end else if (cur_r.rec_end) begin
        out_nxt.kind      = KIND_RECORD_END;
        out_nxt.record_id = cur_r.id;
        cur_nxt.rec_end   = 1'b0;
      end else begin
        out_nxt.kind     = KIND_STREAM_END;
        cur_nxt.strm_end = 1'b0;
      end
    end
    if (q_pop) begin
      cur_nxt = q_data;
    end
  end

  assign out_empty = !out_vld_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    out_r         <= out_nxt;
    cur_r.lead_kind <= cur_nxt.lead_kind;
    cur_r.id      <= cur_nxt.id;
    cur_r.ch      <= cur_nxt.ch;
    if (!rst_n) begin
      out_vld_r      <= 1'b0;
      cur_r.lead_vld <= 1'b0;
      cur_r.rec_end  <= 1'b0;
      cur_r.strm_end <= 1'b0;
    end else begin
      out_vld_r      <= out_vld_nxt;
      cur_r.lead_vld <= cur_nxt.lead_vld;
      cur_r.rec_end  <= cur_nxt.rec_end;
      cur_r.strm_end <= cur_nxt.strm_end;
    end
  end

endmodule

// ===== sv/varint_record_list_parser.sv =====
// channel   | ports                          | handshake
// ----------+--------------------------------+--------------------------------
// input     | in_push, in_full, in_item      | beat when in_push && !in_full
// result    | out_empty, out_pop, out_item   | beat when out_pop && !out_empty
//
// Unless in_full, the front takes a byte per cycle; its state is counters, a shift.
// Each byte yields zero to three results, queued as one bundle between the parts.
// Without out_pop stalls the back part emits one result per cycle, so bytes sustain
// one per cycle while each gives at most one result; the output register caps it.
// Synchronous active-low reset empties the queue and returns the parser to top level.
// in_full rises only when the bundle queue is full; out_pop stalls hold the result.
module varint_record_list_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  vrlp_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output vrlp_pkg::out_item_t out_item
);
  import vrlp_pkg::*;

  logic    q_push, q_full, q_pop, q_empty;
  bundle_t q_wdata, q_rdata;

  assign in_full = q_full;

  vrlp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  vrlp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  vrlp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ===== sv/vrlp_checker.sv =====
module vrlp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input vrlp_pkg::out_item_t out_item
);
  import vrlp_pkg::*;

  a_flags_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_full, out_empty}))
    else $error("queue flag unknown after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_item.kind <= KIND_STREAM_END)
    else $error("result kind out of range");

  a_id_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.kind != KIND_RECORD_END) |-> out_item.record_id == 32'd0)
    else $error("record id set on a result that is not a record end");

  a_stream_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.kind == KIND_STREAM_END) |-> out_item.run_last)
    else $error("stream end not marked as last of its byte");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind varint_record_list_parser vrlp_checker u_vrlp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item)
);
